[hdl/pbosc_pkg.sv]
package pbosc_pkg;

    // waveform codes
    localparam logic [2:0] SH_SINE   = 3'd0;
    localparam logic [2:0] SH_TRI    = 3'd1;
    localparam logic [2:0] SH_SAW    = 3'd2;
    localparam logic [2:0] SH_SQUARE = 3'd3;
    localparam logic [2:0] SH_NOISE  = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_FADE_LEN    = 2'd0;
    localparam logic [1:0] CFG_START_SHAPE = 2'd1;
    localparam logic [1:0] CFG_NOISE_SEED  = 2'd2;

    // PolyBLEP step clamp, Q0.32
    localparam logic [31:0] STEP_MIN = 32'd43;
    localparam logic [31:0] STEP_MAX = 32'd2104533975;

    // quotient bits per division
    localparam logic [6:0] BLEP_STEPS = 7'd32;
    localparam logic [6:0] FADE_STEPS = 7'd44;

    typedef struct packed {
        logic        start;
        logic [31:0] rem0;
        logic [63:0] num0;
        logic [6:0]  steps;
        logic [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } t_div_rsp;

endpackage

[hdl/pbosc_div.sv]
module pbosc_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pbosc_pkg::t_div_req i_req,
    output pbosc_pkg::t_div_rsp o_rsp
);
    import pbosc_pkg::*;

    logic [31:0] r_rem;
    logic [63:0] r_q;
    logic [31:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [32:0] shifted;
    logic        fits;
    logic [32:0] diff;

    assign shifted = {r_rem, r_q[63]};
    assign fits    = shifted >= {1'b0, r_den};
    assign diff    = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem0;
            r_q   <= i_req.num0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= fits ? diff[31:0] : shifted[31:0];
            r_q   <= {r_q[62:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;

endmodule

[hdl/polyblep_waveform_oscillator_top.sv]
// Channel | Direction | Handshake                 | Payload
// in      | input     | i_in_valid / o_in_stall   | i_phase, i_phase_step, i_wanted_shape
// out     | output    | o_out_valid / i_out_stall | o_sample
// cfg     | input     | i_cfg_we (no wait)        | i_cfg_index, i_cfg_data
// One word at a time: stall stays high from acceptance until the result is loaded.
// Triangle and noise are shortest; sine adds table interpolation; saw and square may add a
// BLEP division per edge; a running crossfade adds the second shape and the blend.
// The shared radix-2 divider (one quotient bit a cycle) sets the saw, square and fade cost.
// Synchronous active-low reset puts sequencer, shape, fade state and config at defaults.
// A result waiting on a stalled output holds the sequencer in its last step only.
module polyblep_waveform_oscillator_top #(
    parameter int SINE_POINTS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_phase,
    input  logic [31:0] i_phase_step,
    input  logic [2:0]  i_wanted_shape,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [23:0] o_sample,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import pbosc_pkg::*;

    localparam int IW = $clog2(SINE_POINTS + 1);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DISP   = 5'd1;
    localparam logic [4:0] S_SIN1   = 5'd2;
    localparam logic [4:0] S_SIN2   = 5'd3;
    localparam logic [4:0] S_SIN3   = 5'd4;
    localparam logic [4:0] S_SIN4   = 5'd5;
    localparam logic [4:0] S_SIN5   = 5'd6;
    localparam logic [4:0] S_SIN6   = 5'd7;
    localparam logic [4:0] S_SIN7   = 5'd8;
    localparam logic [4:0] S_B0     = 5'd9;
    localparam logic [4:0] S_DIV    = 5'd10;
    localparam logic [4:0] S_B1     = 5'd11;
    localparam logic [4:0] S_B2     = 5'd12;
    localparam logic [4:0] S_B3     = 5'd13;
    localparam logic [4:0] S_BNEXT  = 5'd14;
    localparam logic [4:0] S_SHDONE = 5'd15;
    localparam logic [4:0] S_F1     = 5'd16;
    localparam logic [4:0] S_F2     = 5'd17;
    localparam logic [4:0] S_F3     = 5'd18;
    localparam logic [4:0] S_FIN    = 5'd19;

    typedef logic signed [23:0] t_rom_arr [0:SINE_POINTS];

    function automatic t_rom_arr f_sine_rom();
        t_rom_arr    tab;
        logic [63:0] x;
        logic [63:0] term;
        longint      sum;
        int          m;
        int          quad;
        int          rem;
        int          p;
        for (int k = 0; k <= SINE_POINTS; k++) begin
            m    = 4 * k;
            quad = (m / SINE_POINTS) % 4;
            rem  = m % SINE_POINTS;
            p    = (quad % 2 == 1) ? SINE_POINTS - rem : rem;
            x    = (64'd1686629713 * 64'(p) + 64'(SINE_POINTS / 2)) / 64'(SINE_POINTS);
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 8; n++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            sum = (sum + 64) >>> 7;
            if (sum > 8388607) begin
                sum = 8388607;
            end
            if (quad >= 2) begin
                sum = -sum;
            end
            tab[k] = 24'(sum);
        end
        return tab;
    endfunction

    localparam t_rom_arr SINE_ROM = f_sine_rom();

    logic [4:0]  r_state;
    logic [4:0]  r_ret;
    logic        r_out_valid;
    logic [23:0] r_sample;
    logic [15:0] r_fade_len;
    logic [2:0]  r_shape_now;
    logic [2:0]  r_shape_next;
    logic [15:0] r_fade_left;
    logic [31:0] r_noise;

    logic [31:0] r_phase;
    logic [31:0] r_step;
    logic [2:0]  r_cur;
    logic [2:0]  r_sh_b;
    logic        r_fading;
    logic        r_pass;
    logic [15:0] r_num;

    logic [31:0] r_ma;
    logic [31:0] r_mb;
    logic [63:0] r_prod;

    logic [IW-1:0]      r_addr;
    logic signed [23:0] r_rom_q;
    logic signed [23:0] r_s0;
    logic [31:0]        r_frac;
    logic               r_neg;

    logic [31:0]        r_bx;
    logic               r_badd;
    logic               r_sqr;
    logic               r_wrap;
    logic signed [35:0] r_acc;

    logic signed [26:0] r_val;
    logic signed [26:0] r_v0;
    logic signed [27:0] r_res;

    t_div_req r_div_req;
    t_div_rsp div_rsp;

    // clamped step, fade decision at acceptance
    logic [31:0] step_clamped;
    logic        fade_start;
    logic [2:0]  fade_nxt;
    logic [15:0] fade_cnt;

    assign step_clamped = (i_phase_step < STEP_MIN) ? STEP_MIN :
                          (i_phase_step > STEP_MAX) ? STEP_MAX : i_phase_step;
    assign fade_start   = (r_fade_left == 16'd0) && (i_wanted_shape != r_shape_now);
    assign fade_nxt     = fade_start ? i_wanted_shape : r_shape_next;
    assign fade_cnt     = fade_start ? r_fade_len : r_fade_left;

    // triangle
    logic [31:0]        tri_d;
    logic [32:0]        tri_sum;
    logic signed [26:0] tri_val;
    assign tri_d   = r_phase[31] ? r_phase - 32'h8000_0000 : 32'h8000_0000 - r_phase;
    assign tri_sum = {1'b0, tri_d} + 33'd64;
    assign tri_val = 27'sd8388608 - $signed({1'b0, tri_sum[32:7]});

    // xorshift32
    logic [31:0]        nz1;
    logic [31:0]        nz2;
    logic [31:0]        nz3;
    logic signed [26:0] noise_val;
    assign nz1       = r_noise ^ (r_noise << 13);
    assign nz2       = nz1 ^ (nz1 >> 17);
    assign nz3       = nz2 ^ (nz2 << 5);
    assign noise_val = $signed({3'b000, nz3[31:8]}) - 27'sd8388608;

    // sine interpolation
    logic signed [24:0] sin_diff;
    logic [24:0]        sin_mag;
    logic [64:0]        prod_rnd;
    logic [25:0]        sin_r;
    logic signed [26:0] sin_val;
    logic signed [26:0] s0_ext;
    assign sin_diff = {r_rom_q[23], r_rom_q} - {r_s0[23], r_s0};
    assign sin_mag  = sin_diff[24] ? 25'(-sin_diff) : 25'(sin_diff);
    assign prod_rnd = {1'b0, r_prod} + 65'h0_8000_0000;
    assign sin_r    = prod_rnd[57:32];
    assign s0_ext   = 27'(r_s0);
    assign sin_val  = r_neg ? s0_ext - $signed({1'b0, sin_r}) : s0_ext + $signed({1'b0, sin_r});

    logic [31:0] sin_hi;
    logic [IW-1:0] sin_idx;
    assign sin_hi  = r_prod[63:32];
    assign sin_idx = (sin_hi >= 32'(SINE_POINTS)) ? IW'(SINE_POINTS - 1) : sin_hi[IW-1:0];

    // PolyBLEP region test
    logic        b_lt;
    logic        b_wrap;
    logic [31:0] b_negx;
    logic [31:0] b_x;
    logic        b_plus_zero;
    assign b_lt        = r_bx < r_step;
    assign b_wrap      = ({1'b0, r_bx} + {1'b0, r_step}) > 33'h1_0000_0000;
    assign b_negx      = 32'd0 - r_bx;
    assign b_x         = b_lt ? r_bx : b_negx;
    assign b_plus_zero = !r_badd;

    logic [32:0]        b_sq;
    logic               b_plus;
    assign b_sq   = prod_rnd[64:32];
    assign b_plus = (r_wrap == r_badd);

    logic [35:0]        acc_mag;
    logic [35:0]        acc_sum;
    logic signed [26:0] acc_val;
    assign acc_mag = r_acc[35] ? 36'(-r_acc) : 36'(r_acc);
    assign acc_sum = acc_mag + 36'd256;
    assign acc_val = r_acc[35] ? -$signed(acc_sum[35:9]) : $signed(acc_sum[35:9]);

    // crossfade
    logic signed [27:0] fd;
    logic [27:0]        fd_mag;
    logic signed [27:0] v0_ext;
    logic [27:0]        fq;
    logic signed [27:0] fade_res;
    assign fd       = {r_val[26], r_val} - {r_v0[26], r_v0};
    assign fd_mag   = fd[27] ? 28'(-fd) : 28'(fd);
    assign v0_ext   = 28'(r_v0);
    assign fq       = div_rsp.quo[27:0];
    assign fade_res = r_neg ? v0_ext - $signed(fq) : v0_ext + $signed(fq);

    logic [23:0] sat_val;
    assign sat_val = (r_res > 28'sd8388607)  ? 24'h7F_FFFF :
                     (r_res < -28'sd8388608) ? 24'h80_0000 : r_res[23:0];

    pbosc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (div_rsp)
    );

    // shared multiplier, registered both sides
    always_ff @(posedge i_clk) begin
        r_prod  <= r_ma * r_mb;
        r_rom_q <= SINE_ROM[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_out_valid     <= 1'b0;
            r_fade_len      <= 16'd5760;
            r_shape_now     <= SH_SINE;
            r_shape_next    <= SH_SINE;
            r_fade_left     <= 16'd0;
            r_noise         <= 32'd1;
            r_div_req.start <= 1'b0;
        end else begin
            r_div_req.start <= 1'b0;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FADE_LEN: r_fade_len <= i_cfg_data[15:0];
                    CFG_START_SHAPE: begin
                        r_shape_now <= i_cfg_data[2:0];
                        r_fade_left <= 16'd0;
                    end
                    CFG_NOISE_SEED: r_noise <= (i_cfg_data == 32'd0) ? 32'd1 : i_cfg_data;
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_phase <= i_phase;
                        r_step  <= step_clamped;
                        r_pass  <= 1'b0;
                        r_state <= S_DISP;
                        if (r_fade_len < 16'd2) begin
                            r_shape_now <= i_wanted_shape;
                            r_fade_left <= 16'd0;
                            r_cur       <= i_wanted_shape;
                            r_fading    <= 1'b0;
                        end else begin
                            r_cur        <= r_shape_now;
                            r_sh_b       <= fade_nxt;
                            r_shape_next <= fade_nxt;
                            r_fading     <= fade_cnt != 16'd0;
                            r_num        <= (fade_cnt <= r_fade_len) ?
                                            r_fade_len - fade_cnt : 16'd0;
                            if (fade_cnt != 16'd0) begin
                                r_fade_left <= fade_cnt - 16'd1;
                                if (fade_cnt == 16'd1) begin
                                    r_shape_now <= fade_nxt;
                                end
                            end
                        end
                    end
                end
                S_DISP: begin
                    unique case (r_cur)
                        SH_SINE: begin
                            r_ma    <= r_phase;
                            r_mb    <= 32'(SINE_POINTS);
                            r_state <= S_SIN1;
                        end
                        SH_TRI: begin
                            r_val   <= tri_val;
                            r_state <= S_SHDONE;
                        end
                        SH_NOISE: begin
                            r_noise <= nz3;
                            r_val   <= noise_val;
                            r_state <= S_SHDONE;
                        end
                        SH_SAW: begin
                            r_acc   <= $signed({3'b000, r_phase, 1'b0}) - 36'sh1_0000_0000;
                            r_bx    <= r_phase;
                            r_badd  <= 1'b0;
                            r_sqr   <= 1'b0;
                            r_state <= S_B0;
                        end
                        default: begin
                            // square, also for the undefined codes
                            r_acc   <= r_phase[31] ? -36'sh1_0000_0000 : 36'sh1_0000_0000;
                            r_bx    <= r_phase;
                            r_badd  <= 1'b1;
                            r_sqr   <= 1'b1;
                            r_state <= S_B0;
                        end
                    endcase
                end
                S_SIN1: r_state <= S_SIN2;
                S_SIN2: begin
                    r_addr  <= sin_idx;
                    r_frac  <= r_prod[31:0];
                    r_state <= S_SIN3;
                end
                S_SIN3: begin
                    r_addr  <= r_addr + IW'(1);
                    r_state <= S_SIN4;
                end
                S_SIN4: begin
                    r_s0    <= r_rom_q;
                    r_state <= S_SIN5;
                end
                S_SIN5: begin
                    r_neg   <= sin_diff[24];
                    r_ma    <= 32'(sin_mag);
                    r_mb    <= r_frac;
                    r_state <= S_SIN6;
                end
                S_SIN6: r_state <= S_SIN7;
                S_SIN7: begin
                    r_val   <= sin_val;
                    r_state <= S_SHDONE;
                end
                S_B0: begin
                    r_wrap <= !b_lt;
                    if (!b_lt && !b_wrap) begin
                        r_state <= S_BNEXT;
                    end else if (b_x == 32'd0) begin
                        // zero distance: full-height correction
                        r_acc   <= b_plus_zero ? r_acc + 36'sh1_0000_0000
                                               : r_acc - 36'sh1_0000_0000;
                        r_state <= S_BNEXT;
                    end else begin
                        r_div_req.start <= 1'b1;
                        r_div_req.rem0  <= b_x;
                        r_div_req.num0  <= 64'd0;
                        r_div_req.steps <= BLEP_STEPS;
                        r_div_req.den   <= r_step;
                        r_ret           <= S_B1;
                        r_state         <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_state <= r_ret;
                    end
                end
                S_B1: begin
                    r_ma    <= 32'd0 - div_rsp.quo[31:0];
                    r_mb    <= 32'd0 - div_rsp.quo[31:0];
                    r_state <= S_B2;
                end
                S_B2: r_state <= S_B3;
                S_B3: begin
                    r_acc   <= b_plus ? r_acc + $signed({3'b000, b_sq})
                                      : r_acc - $signed({3'b000, b_sq});
                    r_state <= S_BNEXT;
                end
                S_BNEXT: begin
                    if (r_sqr && r_badd) begin
                        r_bx    <= r_phase ^ 32'h8000_0000;
                        r_badd  <= 1'b0;
                        r_state <= S_B0;
                    end else begin
                        r_val   <= acc_val;
                        r_state <= S_SHDONE;
                    end
                end
                S_SHDONE: begin
                    if (!r_pass) begin
                        r_v0 <= r_val;
                        if (r_fading) begin
                            r_cur   <= r_sh_b;
                            r_pass  <= 1'b1;
                            r_state <= S_DISP;
                        end else begin
                            r_res   <= 28'(r_val);
                            r_state <= S_FIN;
                        end
                    end else if (r_num == 16'd0) begin
                        r_res   <= v0_ext;
                        r_state <= S_FIN;
                    end else begin
                        r_neg   <= fd[27];
                        r_ma    <= 32'(fd_mag);
                        r_mb    <= 32'(r_num);
                        r_state <= S_F1;
                    end
                end
                S_F1: r_state <= S_F2;
                S_F2: begin
                    r_div_req.start <= 1'b1;
                    r_div_req.rem0  <= 32'd0;
                    r_div_req.num0  <= {r_prod[43:0], 20'd0};
                    r_div_req.steps <= FADE_STEPS;
                    r_div_req.den   <= 32'(r_fade_len - 16'd1);
                    r_ret           <= S_F3;
                    r_state         <= S_DIV;
                end
                S_F3: begin
                    r_res   <= fade_res;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    // hold until the output register is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_sample    <= sat_val;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = !i_rst_n || (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;

endmodule

[hdl/pbosc_chk.sv]
module pbosc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [23:0] o_sample
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sample))
        else $error("stalled output word changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again while busy");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a word in work");

endmodule

bind polyblep_waveform_oscillator_top pbosc_chk u_pbosc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_sample    (o_sample)
);

[verif/polyblep_waveform_oscillator_top_tb.sv]
`timescale 1ns / 1ps

module polyblep_waveform_oscillator_top_tb;
    import pbosc_pkg::*;

    localparam int TABLE_POINTS = 1024;
    localparam longint ONE_Q32 = 64'sd4294967296;
    localparam int STALL_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [31:0] i_phase = '0;
    logic [31:0] i_phase_step = '0;
    logic [2:0]  i_wanted_shape = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [23:0] o_sample;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    polyblep_waveform_oscillator_top #(.SINE_POINTS(TABLE_POINTS)) uut (.*);

    always #5 i_clk = ~i_clk;

    // shadow state of the oscillator
    int unsigned fade_len_reg, start_shape_reg;
    logic [2:0]  cur_shape, next_shape;
    int unsigned fade_remaining;
    logic [31:0] lfsr_word;
    longint      sine_table[TABLE_POINTS + 1];

    logic [23:0] sample_queue[$];
    int          mismatches, samples_seen, words_sent, idle_cycles;
    bit          calm, hold_out, long_hold;

    function automatic longint rnd_shift(longint v, int k);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (64'sd1 <<< (k - 1))) >>> k;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint quarter_wave(longint p);
        longint x, term, sum;
        x = (64'sd1686629713 * p + TABLE_POINTS / 2) / TABLE_POINTS;
        term = x;
        sum = x;
        for (int n = 1; n <= 8; n++) begin
            term = (term * x) >>> 30;
            term = (term * x) >>> 30;
            term = term / ((2 * n) * (2 * n + 1));
            if (n % 2) sum -= term; else sum += term;
        end
        if (sum < 0) sum = 0;
        sum = (sum + 64) >>> 7;
        if (sum > 8388607) sum = 8388607;
        return sum;
    endfunction

    function automatic void fill_sine_table();
        int m, quad, rem, p;
        for (int k = 0; k <= TABLE_POINTS; k++) begin
            m = 4 * k;
            quad = (m / TABLE_POINTS) % 4;
            rem = m % TABLE_POINTS;
            p = (quad % 2) ? TABLE_POINTS - rem : rem;
            sine_table[k] = (quad >= 2) ? -quarter_wave(p) : quarter_wave(p);
        end
    endfunction

    function automatic longint sine_at(logic [31:0] ph);
        logic [63:0] pos;
        longint idx, frac, diff;
        pos = {32'd0, ph} * TABLE_POINTS;
        idx = pos[63:32];
        frac = {32'd0, pos[31:0]};
        if (idx >= TABLE_POINTS) idx = TABLE_POINTS - 1;
        diff = sine_table[idx + 1] - sine_table[idx];
        // diff*frac fits: |diff| < 2^24, frac < 2^32
        return sine_table[idx] + rnd_shift(diff * frac, 32);
    endfunction

    function automatic longint blep_sq(longint x, longint s);
        logic [63:0] t, w, sq;
        t = (64'(x) << 32) / 64'(s);
        w = 64'(ONE_Q32) - t;
        if (w >= 64'(ONE_Q32)) return ONE_Q32;
        sq = w * w + 64'h8000_0000;
        return longint'(sq >> 32);
    endfunction

    function automatic longint blep(longint p, longint s);
        if (p < s) return -blep_sq(p, s);
        if (p > ONE_Q32 - s) return blep_sq(ONE_Q32 - p, s);
        return 0;
    endfunction

    function automatic longint shape_value(logic [2:0] shape, logic [31:0] ph,
                                           logic [31:0] inc);
        longint p, s, d, v;
        p = {32'd0, ph};
        if (shape == SH_SINE) return sine_at(ph);
        if (shape == SH_NOISE) begin
            lfsr_word = lfsr_word ^ (lfsr_word << 13);
            lfsr_word = lfsr_word ^ (lfsr_word >> 17);
            lfsr_word = lfsr_word ^ (lfsr_word << 5);
            return longint'({40'd0, lfsr_word[31:8]}) - 8388608;
        end
        if (shape == SH_TRI) begin
            d = (p >= 64'sh8000_0000) ? p - 64'sh8000_0000 : 64'sh8000_0000 - p;
            return 8388608 - ((d + 64) >>> 7);
        end
        s = (inc < STEP_MIN) ? STEP_MIN : ((inc > STEP_MAX) ? STEP_MAX : inc);
        if (shape == SH_SAW) return rnd_shift(2 * p - ONE_Q32 - blep(p, s), 9);
        // square, also for undefined codes
        v = (p < 64'sh8000_0000) ? ONE_Q32 : -ONE_Q32;
        v = v + blep(p, s) - blep({32'd0, ph ^ 32'h8000_0000}, s);
        return rnd_shift(v, 9);
    endfunction

    function automatic logic [23:0] predict_sample(logic [31:0] ph, logic [31:0] inc,
                                                   logic [2:0] want);
        longint v, dst, num, den;
        if (fade_len_reg < 2) begin
            if (fade_remaining != 0) begin
                cur_shape = next_shape;
                fade_remaining = 0;
            end
            cur_shape = want;
            v = shape_value(cur_shape, ph, inc);
        end else begin
            if (fade_remaining == 0 && want != cur_shape) begin
                next_shape = want;
                fade_remaining = fade_len_reg;
            end
            v = shape_value(cur_shape, ph, inc);
            if (fade_remaining != 0) begin
                dst = shape_value(next_shape, ph, inc);
                num = (fade_remaining <= fade_len_reg) ? fade_len_reg - fade_remaining : 0;
                den = fade_len_reg - 1;
                v = v + ((dst - v) * num) / den;
                fade_remaining--;
                if (fade_remaining == 0) cur_shape = next_shape;
            end
        end
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return v[23:0];
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_FADE_LEN: fade_len_reg = val[15:0];
            CFG_START_SHAPE: begin
                start_shape_reg = val[2:0];
                cur_shape = val[2:0];
                fade_remaining = 0;
            end
            CFG_NOISE_SEED: lfsr_word = (val == 0) ? 32'd1 : val;
            default: ;
        endcase
    endtask

    // let every expected word drain before touching registers
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sample_queue.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // valid stays high after a handshake until the next word or an idle cycle replaces it
    task automatic send_word(logic [31:0] ph, logic [31:0] inc, logic [2:0] want);
        while (!calm && $urandom_range(99) < 15) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_phase <= ph;
        i_phase_step <= inc;
        i_wanted_shape <= want;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sample_queue.push_back(predict_sample(ph, inc, want));
        words_sent++;
    endtask

    function automatic logic [31:0] pick_step();
        case ($urandom_range(5))
            0: return $urandom_range(60);
            1: return STEP_MAX - 5 + $urandom_range(20);
            2: return $urandom_range(32'h0100_0000);
            default: return $urandom();
        endcase
    endfunction

    // phase near a discontinuity so the BLEP corrections are exercised
    function automatic logic [31:0] pick_phase(logic [31:0] inc);
        logic [31:0] off;
        off = (inc == 0) ? 32'd0 : $urandom() % inc;
        case ($urandom_range(3))
            0: return off;
            1: return 32'd0 - off;
            2: return 32'h8000_0000 + off - (inc >> 1);
            default: return $urandom();
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] edges[6];
        edges = '{32'd0, 32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h4000_0000};
        write_reg(CFG_FADE_LEN, 32'd0);
        for (int sh = 0; sh < 8; sh++)
            send_word(edges[sh % 6], (sh % 2) ? 32'hFFFF_FFFF : 32'd0, sh[2:0]);
        send_word(32'd20, 32'd43, SH_SAW);
        send_word(32'hFFFF_FFF0, 32'd43, SH_SQUARE);
        send_word(32'h8000_0010, STEP_MAX, SH_SQUARE);
        send_word(32'h7FFF_FFF0, STEP_MAX + 1, SH_SQUARE);
        send_word(32'hFFFF_FFFF, 32'h1234_5678, SH_SINE);
        wait_drained();
        write_reg(CFG_FADE_LEN, 32'd1);
        send_word(32'h1000_0000, 32'd1000, SH_NOISE);
        send_word(32'h1000_0000, 32'd1000, SH_TRI);
        wait_drained();
    endtask

    task automatic run_random(int count, logic [2:0] bias);
        logic [31:0] inc;
        logic [2:0]  want;
        for (int n = 0; n < count; n++) begin
            inc = pick_step();
            want = ($urandom_range(9) < 6) ? bias : 3'($urandom_range(7));
            if ($urandom_range(9) == 0) bias = 3'($urandom_range(4));
            send_word(pick_phase(inc), inc, want);
        end
        wait_drained();
    endtask

    task automatic test_crossfades();
        write_reg(CFG_NOISE_SEED, 32'd0);
        write_reg(CFG_START_SHAPE, SH_TRI);
        write_reg(CFG_FADE_LEN, 32'd2);
        run_random(200, SH_SAW);
        write_reg(CFG_FADE_LEN, 32'd7);
        write_reg(CFG_NOISE_SEED, 32'hFFFF_FFFF);
        run_random(200, SH_SQUARE);
        write_reg(CFG_FADE_LEN, 32'd40);
        write_reg(CFG_START_SHAPE, SH_NOISE);
        run_random(200, SH_SINE);
    endtask

    task automatic test_fade_shrink();
        // drop the length mid-fade so the new shape weight stays zero for a while
        write_reg(CFG_FADE_LEN, 32'd65535);
        write_reg(CFG_START_SHAPE, SH_SINE);
        run_random(20, SH_TRI);
        write_reg(CFG_FADE_LEN, 32'd5);
        run_random(150, SH_SAW);
        write_reg(CFG_START_SHAPE, 32'd7);
        write_reg(CFG_FADE_LEN, 32'd3);
        run_random(150, SH_NOISE);
    endtask

    task automatic test_backpressure();
        write_reg(CFG_FADE_LEN, 32'd5760);
        write_reg(CFG_NOISE_SEED, $urandom() | 32'd1);
        calm = 1'b1;
        long_hold = 1'b1;
        run_random(200, SH_SQUARE);
        long_hold = 1'b0;
        run_random(200, SH_NOISE);
        calm = 1'b0;
        write_reg(CFG_FADE_LEN, 32'd16);
        run_random(300, SH_SINE);
    endtask

    // receiver side: stall at random, once for a long counted stretch
    initial begin
        int hold;
        forever begin
            @(posedge i_clk);
            if (long_hold && !hold_out) begin
                hold_out = 1'b1;
                i_out_stall <= 1'b1;
                for (hold = 0; hold < 400; hold++) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= (!calm && $urandom_range(99) < 15);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            samples_seen++;
            if (sample_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected sample %h", o_sample);
            end else if (sample_queue[0] !== o_sample) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("sample %0d: expected %h got %h", samples_seen,
                             sample_queue[0], o_sample);
                void'(sample_queue.pop_front());
            end else begin
                void'(sample_queue.pop_front());
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        fade_len_reg = 5760;
        start_shape_reg = 0;
        cur_shape = SH_SINE;
        next_shape = SH_SINE;
        fade_remaining = 0;
        lfsr_word = 32'd1;
        fill_sine_table();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_random(20, SH_SINE);
        test_directed();
        test_crossfades();
        test_fade_shrink();
        test_backpressure();
        repeat (200) @(posedge i_clk);
        $display("Sent %0d words over fade lengths 0..65535, all shapes and codes,",
                 words_sent);
        $display("checked %0d samples with random and long output stalls", samples_seen);
        if (mismatches == 0 && sample_queue.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
hdl/pbosc_pkg.sv
hdl/pbosc_div.sv
hdl/polyblep_waveform_oscillator_top.sv
hdl/pbosc_chk.sv
verif/polyblep_waveform_oscillator_top_tb.sv
